// ----- sv/kbt_pkg.sv -----
// Shared types and codes for the Kruskal bottleneck tracker.
`timescale 1ns / 1ps
package kbt_pkg;

  typedef enum logic [1:0] {
    FN_EDGE    = 2'd0,
    FN_READ    = 2'd1,
    FN_RESTART = 2'd2,
    FN_NONE    = 2'd3
  } kbt_func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_APPLY,
    ST_DONE
  } kbt_state_e;

  typedef struct packed {
    logic shift;
    logic restart;
  } ring_ctl_t;

  localparam logic [7:0] NODE_COUNT_RST = 8'd128;

endpackage

// ----- sv/kbt_cell.sv -----
// One ring cell: holds the component label and bottleneck of one node slot.
`timescale 1ns / 1ps
module kbt_cell
  import kbt_pkg::*;
#(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 32,
  parameter int INDEX       = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ring_ctl_t                    ring_i,
  input  logic [$clog2(MAX_NODES)-1:0] prev_label_i,
  input  logic [WEIGHT_BITS-1:0]       prev_bn_i,
  output logic [$clog2(MAX_NODES)-1:0] label_o,
  output logic [WEIGHT_BITS-1:0]       bn_o
);

  localparam int IDX_W = $clog2(MAX_NODES);

  logic [IDX_W-1:0]       label_q;
  logic [WEIGHT_BITS-1:0] bn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q <= IDX_W'(INDEX);
      bn_q    <= '0;
    end else if (ring_i.restart) begin
      label_q <= IDX_W'(INDEX);
      bn_q    <= '0;
    end else if (ring_i.shift) begin
      label_q <= prev_label_i;
      bn_q    <= prev_bn_i;
    end
  end

  assign label_o = label_q;
  assign bn_o    = bn_q;

endmodule

// ----- sv/kbt_ctrl.sv -----
// Sequencer: command decode, ring scan and relabel passes, result register.
`timescale 1ns / 1ps
module kbt_ctrl
  import kbt_pkg::*;
#(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic [6:0]                   node_a_i,
  input  logic [6:0]                   node_b_i,
  input  logic [WEIGHT_BITS-1:0]       edge_weight_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o,
  output logic                         spanning_done_o,
  output logic [WEIGHT_BITS-1:0]       bottleneck_o,
  output logic                         bad_index_o,
  input  logic [$clog2(MAX_NODES)-1:0] head_label_i,
  input  logic [WEIGHT_BITS-1:0]       head_bn_i,
  output logic [$clog2(MAX_NODES)-1:0] tail_label_o,
  output logic [WEIGHT_BITS-1:0]       tail_bn_o,
  output ring_ctl_t                    ring_o
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CW    = ($clog2(MAX_NODES + 1) > 8) ? $clog2(MAX_NODES + 1) : 8;
  localparam int CW1   = CW + 1;
  localparam int IW    = (IDX_W > 7) ? IDX_W : 7;

  kbt_state_e state_q, state_d;

  logic [IDX_W-1:0]       cnt_q;
  kbt_func_e              func_q;
  logic [6:0]             a_q, b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [IDX_W-1:0]       la_q, lb_q, l0_q;
  logic [WEIGHT_BITS-1:0] bn_q;
  logic                   acc_q, bad_q;
  logic [CW-1:0]          edges_q;
  logic [7:0]             node_count_q;

  logic                   out_valid_q, acc_out_q, done_out_q, bad_out_q;
  logic [WEIGHT_BITS-1:0] bn_out_q;

  logic [CW-1:0]    n_eff;
  logic             done_now, a_bad, b_bad, in_xfer, cnt_last, out_load, hit0;
  logic [IDX_W-1:0] head_idx, other;
  kbt_func_e        func_in;

  assign func_in  = kbt_func_e'(func_i);
  assign n_eff    = (CW'(node_count_q) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                         : CW'(node_count_q);
  assign done_now = (CW1'(edges_q) + CW1'(1)) >= CW1'(n_eff);
  assign a_bad    = CW'(node_a_i) >= n_eff;
  assign b_bad    = CW'(node_b_i) >= n_eff;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cnt_last = cnt_q == IDX_W'(MAX_NODES - 1);
  assign head_idx = IDX_W'(MAX_NODES - 1) - cnt_q;
  assign hit0     = (la_q == l0_q) || (lb_q == l0_q);
  assign other    = (la_q == l0_q) ? lb_q : la_q;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (func_in)
            FN_EDGE: state_d = (a_bad || b_bad || done_now) ? ST_DONE : ST_SCAN;
            FN_READ: state_d = a_bad ? ST_DONE : ST_SCAN;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_last) begin
          state_d = (func_q == FN_READ) ? ST_DONE : ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = (la_q == lb_q) ? ST_DONE : ST_APPLY;
      ST_APPLY: begin
        if (cnt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = state_q != ST_IDLE;
    ring_o.shift   = (state_q == ST_SCAN) || (state_q == ST_APPLY);
    ring_o.restart = in_xfer && (func_in == FN_RESTART);
    tail_label_o   = head_label_i;
    tail_bn_o      = head_bn_i;
    if (state_q == ST_APPLY) begin
      if (hit0 && (head_label_i == other)) begin
        tail_bn_o = w_q;
      end
      if (head_label_i == lb_q) begin
        tail_label_o = la_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      edges_q      <= '0;
      node_count_q <= NODE_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (ring_o.shift) begin
        cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
      end
      if (ring_o.restart) begin
        edges_q <= '0;
      end else if ((state_q == ST_APPLY) && cnt_last) begin
        edges_q <= edges_q + CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_in;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      w_q    <= edge_weight_i;
      acc_q  <= 1'b0;
      bn_q   <= '0;
      unique case (func_in)
        FN_EDGE: bad_q <= a_bad || b_bad;
        FN_READ: bad_q <= a_bad;
        default: bad_q <= 1'b0;
      endcase
    end
    if (state_q == ST_SCAN) begin
      if (IW'(head_idx) == IW'(a_q)) begin
        la_q <= head_label_i;
        if (func_q == FN_READ) begin
          bn_q <= head_bn_i;
        end
      end
      if (IW'(head_idx) == IW'(b_q)) begin
        lb_q <= head_label_i;
      end
      if (head_idx == '0) begin
        l0_q <= head_label_i;
      end
    end
    if ((state_q == ST_APPLY) && cnt_last) begin
      acc_q <= 1'b1;
    end
    if (out_load) begin
      acc_out_q  <= acc_q;
      done_out_q <= done_now;
      bn_out_q   <= bn_q;
      bad_out_q  <= bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_out_q;
  assign spanning_done_o = done_out_q;
  assign bottleneck_o    = bn_out_q;
  assign bad_index_o     = bad_out_q;

endmodule

// ----- sv/kruskal_bottleneck_tracker_core.sv -----
// Top level: ring of node cells driven by the command sequencer.
// Item flow: an edge merge runs a scan pass, a decide step and a relabel pass; an edge
// whose ends share a label stops after the decide step; a read runs the scan pass only;
// a bad index, an edge on a complete tree, restart or func 3 goes straight to the result.
// One item at a time; the next input is taken once the result is loaded, even while it stalls.
// Reset (async, active low): own-index labels, zero bottlenecks and edge count, node_count 128.
`timescale 1ns / 1ps
module kruskal_bottleneck_tracker_core
  import kbt_pkg::*;
#(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [6:0]             node_a_i,
  input  logic [6:0]             node_b_i,
  input  logic [WEIGHT_BITS-1:0] edge_weight_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic                   spanning_done_o,
  output logic [WEIGHT_BITS-1:0] bottleneck_o,
  output logic                   bad_index_o
);

  localparam int IDX_W = $clog2(MAX_NODES);

  ring_ctl_t              ring;
  logic [IDX_W-1:0]       label_w [MAX_NODES];
  logic [WEIGHT_BITS-1:0] bn_w    [MAX_NODES];
  logic [IDX_W-1:0]       tail_label;
  logic [WEIGHT_BITS-1:0] tail_bn;

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    if (k == 0) begin : g_first
      kbt_cell #(
        .MAX_NODES  (MAX_NODES),
        .WEIGHT_BITS(WEIGHT_BITS),
        .INDEX      (k)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ring_i      (ring),
        .prev_label_i(tail_label),
        .prev_bn_i   (tail_bn),
        .label_o     (label_w[k]),
        .bn_o        (bn_w[k])
      );
    end else begin : g_rest
      kbt_cell #(
        .MAX_NODES  (MAX_NODES),
        .WEIGHT_BITS(WEIGHT_BITS),
        .INDEX      (k)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ring_i      (ring),
        .prev_label_i(label_w[k-1]),
        .prev_bn_i   (bn_w[k-1]),
        .label_o     (label_w[k]),
        .bn_o        (bn_w[k])
      );
    end
  end

  kbt_ctrl #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .edge_weight_i  (edge_weight_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .spanning_done_o(spanning_done_o),
    .bottleneck_o   (bottleneck_o),
    .bad_index_o    (bad_index_o),
    .head_label_i   (label_w[MAX_NODES-1]),
    .head_bn_i      (bn_w[MAX_NODES-1]),
    .tail_label_o   (tail_label),
    .tail_bn_o      (tail_bn),
    .ring_o         (ring)
  );

endmodule

// ----- sv/kbt_checker.sv -----
// Port-level assertions for the tracker core, bound to the top level.
`timescale 1ns / 1ps
module kbt_checker #(
  parameter int WEIGHT_BITS = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   accepted_o,
  input logic [WEIGHT_BITS-1:0] bottleneck_o,
  input logic                   bad_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the item finished");

  a_bad_no_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(bad_index_o && accepted_o))
    else $error("bad index result reports a merge");

  a_bn_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bottleneck_o != '0) |-> !accepted_o && !bad_index_o)
    else $error("bottleneck set on a non-read result");

endmodule

bind kruskal_bottleneck_tracker_core kbt_checker #(
  .WEIGHT_BITS(WEIGHT_BITS)
) u_kbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .accepted_o  (accepted_o),
  .bottleneck_o(bottleneck_o),
  .bad_index_o (bad_index_o)
);

// ----- sim/kbt_checker.sv -----
// Checker that predicts tracker results from the observed transfers and compares them.
`timescale 1ns / 1ps
module kbt_scoreboard
  import kbt_pkg::*;
#(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [1:0]             func_i,
  input  logic [6:0]             node_a_i,
  input  logic [6:0]             node_b_i,
  input  logic [WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic                   accepted_i,
  input  logic                   spanning_done_i,
  input  logic [WEIGHT_BITS-1:0] bottleneck_i,
  input  logic                   bad_index_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     merges_o
);

  typedef struct packed {
    logic                   accepted;
    logic                   spanning_done;
    logic [WEIGHT_BITS-1:0] bottleneck;
    logic                   bad_index;
  } tracker_result_t;

  logic [6:0]             component_of [MAX_NODES];
  logic [WEIGHT_BITS-1:0] reach_weight [MAX_NODES];
  int unsigned            merges_taken;
  logic [7:0]             node_count;
  tracker_result_t        expected_results [$];
  int                     mismatches;
  int                     results_seen;
  int                     merges_seen;

  function automatic int unsigned active_nodes();
    return (node_count > MAX_NODES) ? MAX_NODES : node_count;
  endfunction

  function automatic bit tree_complete();
    return (merges_taken + 1 >= active_nodes());
  endfunction

  function automatic void clear_forest();
    for (int k = 0; k < MAX_NODES; k++) begin
      component_of[k] = 7'(k);
      reach_weight[k] = '0;
    end
    merges_taken = 0;
  endfunction

  function automatic tracker_result_t apply_command(kbt_func_e fn, logic [6:0] a, logic [6:0] b,
                                                    logic [WEIGHT_BITS-1:0] w);
    tracker_result_t r;
    int unsigned     n;
    logic [6:0]      la;
    logic [6:0]      lb;
    logic [6:0]      l0;
    logic [6:0]      other;
    r = '0;
    n = active_nodes();
    case (fn)
      FN_EDGE: begin
        if (a >= n || b >= n) begin
          r.bad_index = 1'b1;
        end else if (!tree_complete()) begin
          la = component_of[a];
          lb = component_of[b];
          if (la != lb) begin
            l0 = component_of[0];
            if (la == l0 || lb == l0) begin
              other = (la == l0) ? lb : la;
              for (int k = 0; k < MAX_NODES; k++) begin
                if (component_of[k] == other) reach_weight[k] = w;
              end
            end
            for (int k = 0; k < MAX_NODES; k++) begin
              if (component_of[k] == lb) component_of[k] = la;
            end
            merges_taken++;
            r.accepted = 1'b1;
          end
        end
      end
      FN_READ: begin
        if (a >= n) r.bad_index = 1'b1;
        else r.bottleneck = reach_weight[a];
      end
      FN_RESTART: begin
        clear_forest();
      end
      default: begin
      end
    endcase
    r.spanning_done = tree_complete();
    return r;
  endfunction

  task automatic compare_result(tracker_result_t got);
    tracker_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result acc=%0b done=%0b bn=%h bad=%0b", $realtime,
                 got.accepted, got.spanning_done, got.bottleneck, got.bad_index);
      end
    end else begin
      want = expected_results.pop_front();
      if (got.accepted !== want.accepted || got.spanning_done !== want.spanning_done ||
          got.bottleneck !== want.bottleneck || got.bad_index !== want.bad_index) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp acc=%0b done=%0b bn=%h bad=%0b", $realtime,
                   want.accepted, want.spanning_done, want.bottleneck, want.bad_index);
          $display("%0t:          got acc=%0b done=%0b bn=%h bad=%0b", $realtime,
                   got.accepted, got.spanning_done, got.bottleneck, got.bad_index);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tracker_result_t got;
    tracker_result_t predicted;
    if (!rst_ni) begin
      node_count = NODE_COUNT_RST;
      clear_forest();
      expected_results.delete();
      mismatches   = 0;
      results_seen = 0;
      merges_seen  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      merges_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.accepted      = accepted_i;
        got.spanning_done = spanning_done_i;
        got.bottleneck    = bottleneck_i;
        got.bad_index     = bad_index_i;
        results_seen++;
        if (accepted_i === 1'b1) merges_seen++;
        compare_result(got);
      end
      if (cfg_we_i) node_count = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        predicted = apply_command(kbt_func_e'(func_i), node_a_i, node_b_i, edge_weight_i);
        expected_results.insert(expected_results.size(), predicted);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
      results_o    <= results_seen;
      merges_o     <= merges_seen;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top: clock, reset, stimulus and verdict for the bottleneck tracker core.
`timescale 1ns / 1ps
module testbench
  import kbt_pkg::*;
();

  localparam int MAX_NODES   = 128;
  localparam int WEIGHT_BITS = 32;
  localparam int IDLE_LIMIT  = 4000;
  localparam int ITEM_TARGET = 1850;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [7:0]             cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             func;
  logic [6:0]             node_a;
  logic [6:0]             node_b;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic                   out_valid;
  logic                   out_stall;
  logic                   accepted;
  logic                   spanning_done;
  logic [WEIGHT_BITS-1:0] bottleneck;
  logic                   bad_index;

  int              check_fails;
  int              check_pending;
  int              check_results;
  int              check_merges;
  int              items_sent;
  int              cfg_writes;
  int              idle_cycles;
  bit              steady;
  longint unsigned weight_now;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  kruskal_bottleneck_tracker_core #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .edge_weight_i  (edge_weight),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_o     (accepted),
    .spanning_done_o(spanning_done),
    .bottleneck_o   (bottleneck),
    .bad_index_o    (bad_index)
  );

  kbt_scoreboard #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) tracker_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .func_i         (func),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .edge_weight_i  (edge_weight),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_i     (accepted),
    .spanning_done_i(spanning_done),
    .bottleneck_i   (bottleneck),
    .bad_index_i    (bad_index),
    .fail_count_o   (check_fails),
    .pending_o      (check_pending),
    .results_o      (check_results),
    .merges_o       (check_merges)
  );

  task automatic offer_item(kbt_func_e fn, logic [6:0] a, logic [6:0] b,
                            logic [WEIGHT_BITS-1:0] w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= fn;
    node_a      <= a;
    node_b      <= b;
    edge_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_node_count(logic [7:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (check_pending != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [WEIGHT_BITS-1:0] next_weight();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) weight_now += $urandom_range(0, 3);
    else if (pick == 8) weight_now += $urandom_range(1, 65535);
    else if (pick == 9) weight_now += $urandom_range(0, 1 << 24);
    if (weight_now > 64'hFFFF_FFFF) weight_now = 64'hFFFF_FFFF;
    return weight_now[WEIGHT_BITS-1:0];
  endfunction

  task automatic offer_noise(int unsigned n);
    int unsigned pick;
    logic [6:0]  bad_node;
    pick = $urandom_range(0, 9);
    if (pick < 4 && n > 0) begin
      offer_item(FN_EDGE, 7'($urandom_range(0, n - 1)), 7'($urandom_range(0, n - 1)),
                 next_weight());
    end else if (pick < 6 && n > 0) begin
      offer_item(FN_READ, 7'($urandom_range(0, n - 1)), 7'($urandom), $urandom);
    end else if (pick < 8 && n < MAX_NODES) begin
      bad_node = 7'($urandom_range(n, 127));
      case ($urandom_range(0, 2))
        0: offer_item(FN_READ, bad_node, 7'($urandom), $urandom);
        1: offer_item(FN_EDGE, bad_node, 7'($urandom), next_weight());
        default: offer_item(FN_EDGE, 7'($urandom), bad_node, next_weight());
      endcase
    end else if (pick == 8) begin
      offer_item(FN_NONE, 7'($urandom), 7'($urandom), $urandom);
    end else begin
      offer_item(FN_READ, 7'($urandom), 7'($urandom), $urandom);
    end
  endtask

  task automatic run_phase(int phase);
    int unsigned pick;
    logic [7:0]  count;
    int unsigned n;
    int          order [MAX_NODES];
    int          t;
    int          tmp;
    logic [6:0]  a;
    logic [6:0]  b;
    pick = $urandom_range(0, 99);
    if (phase == 0) count = 8'd128;
    else if (phase == 1) count = 8'd255;
    else if (pick < 84) count = 8'($urandom_range(2, 12));
    else if (pick < 94) count = 8'($urandom_range(13, 48));
    else if (pick < 95) count = 8'd128;
    else if (pick < 96) count = 8'($urandom_range(129, 254));
    else if (pick < 98) count = 8'd0;
    else count = 8'd1;
    write_node_count(count);
    n = (count > MAX_NODES) ? MAX_NODES : count;
    steady = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: weight_now = 0;
      1: weight_now = 64'hFFFF_FF00;
      2: weight_now = $urandom_range(0, 4096);
      default: weight_now = $urandom;
    endcase
    if ($urandom_range(0, 6) != 0) begin
      offer_item(FN_RESTART, 7'($urandom), 7'($urandom), $urandom);
    end
    // shuffle node order, then grow a random tree over it
    for (int j = 0; j < n; j++) order[j] = j;
    for (int j = n - 1; j > 0; j--) begin
      t = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[t];
      order[t] = tmp;
    end
    for (int j = 1; j < n; j++) begin
      if ($urandom_range(0, 3) == 0) offer_noise(n);
      a = 7'(order[j]);
      b = 7'(order[$urandom_range(0, j - 1)]);
      if ($urandom_range(0, 1)) offer_item(FN_EDGE, a, b, next_weight());
      else offer_item(FN_EDGE, b, a, next_weight());
    end
    if (n <= 1) begin
      repeat (4) offer_noise(n);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        offer_item(FN_EDGE, 7'($urandom_range(0, n - 1)), 7'($urandom_range(0, n - 1)),
                   next_weight());
      end
    end
    if (n <= 16) begin
      for (int j = 0; j < n; j++) offer_item(FN_READ, 7'(j), 7'($urandom), $urandom);
    end else begin
      repeat (8) offer_item(FN_READ, 7'($urandom_range(0, n - 1)), 7'($urandom), $urandom);
    end
  endtask

  initial begin : stimulus
    int phase;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    func        = '0;
    node_a      = '0;
    node_b      = '0;
    edge_weight = '0;
    steady      = 1'b0;
    items_sent  = 0;
    cfg_writes  = 0;
    weight_now  = 0;
    phase       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_item(FN_READ, 7'd0, 7'd0, '0);
    offer_item(FN_READ, 7'd127, 7'd127, 32'hFFFF_FFFF);
    offer_item(FN_EDGE, 7'd0, 7'd127, 32'h0000_0000);
    offer_item(FN_EDGE, 7'd127, 7'd0, 32'h0000_0000);
    offer_item(FN_EDGE, 7'd5, 7'd6, 32'h0000_0001);
    offer_item(FN_EDGE, 7'd6, 7'd0, 32'hFFFF_FFFF);
    offer_item(FN_READ, 7'd5, 7'd0, '0);
    offer_item(FN_READ, 7'd6, 7'd0, '0);
    offer_item(FN_NONE, 7'd127, 7'd127, 32'hFFFF_FFFF);
    offer_item(FN_RESTART, 7'd0, 7'd0, '0);
    offer_item(FN_READ, 7'd5, 7'd0, '0);
    write_node_count(8'd1);
    offer_item(FN_EDGE, 7'd0, 7'd0, 32'h10);
    offer_item(FN_READ, 7'd1, 7'd0, '0);
    offer_item(FN_EDGE, 7'd0, 7'd1, 32'h11);
    write_node_count(8'd0);
    offer_item(FN_READ, 7'd0, 7'd0, '0);
    offer_item(FN_EDGE, 7'd0, 7'd0, 32'h12);
    offer_item(FN_RESTART, 7'd0, 7'd0, '0);
    offer_item(FN_NONE, 7'd0, 7'd0, '0);
    write_node_count(8'd200);
    offer_item(FN_EDGE, 7'd127, 7'd0, 32'd3);
    offer_item(FN_READ, 7'd127, 7'd0, '0);
    offer_item(FN_EDGE, 7'd126, 7'd125, 32'd4);
    offer_item(FN_EDGE, 7'd124, 7'd123, 32'd5);
    write_node_count(8'd3);
    offer_item(FN_EDGE, 7'd0, 7'd1, 32'd6);
    offer_item(FN_READ, 7'd2, 7'd0, '0);

    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (check_pending != 0);
    repeat (300) @(posedge clk);
    $display("summary: %0d items in %0d phases, %0d node_count writes, %0d results, %0d merges",
             items_sent, phase, cfg_writes, check_results, check_merges);
    if (check_fails == 0 && check_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : receiver
    int hold;
    int delivered;
    out_stall = 1'b0;
    delivered = 0;
    forever begin
      // long hold-off fills the block and backs up the sender
      if (delivered == 300 || delivered == 1100) hold = 400;
      else if ((delivered / 40) % 4 == 1) hold = 0;
      else hold = $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      delivered++;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/kbt_pkg.sv
sv/kbt_cell.sv
sv/kbt_ctrl.sv
sv/kruskal_bottleneck_tracker_core.sv
sv/kbt_checker.sv
sim/kbt_checker.sv
sim/testbench.sv
